### rtl/mfrt_pkg.sv
// Package for the matrix flip, rotate and transpose core.
// Holds the register indexes, reorder modes, state type and fixed field widths.
// No dependencies.
package mfrt_pkg;

    localparam int ELEM_W = 32;
    localparam int CFG_W = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COL_COUNT    = 2'd1,
        REG_REORDER_MODE = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_MIRROR    = 2'd0,
        MODE_FLIP      = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_TRANSPOSE = 2'd3
    } mode_t;

    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 4'd8;
    localparam logic [CFG_W-1:0] COL_COUNT_RESET = 4'd8;

endpackage

### rtl/matrix_flip_rotate_transpose_core.sv
// Matrix flip, rotate and transpose core: loads a matrix into one memory and
// reads it back in reordered order. Depends on mfrt_pkg.
// Loading writes each accepted element to the next memory address; the item that
// completes the matrix moves the state to emission, and the first result is then
// read from memory into the output register. Emission reads one element per cycle
// from the single read port unless the output stalls; input stalls during emission.
// Reset clears the control state and sets 8 x 8 mirror mode; memory is not cleared.
module matrix_flip_rotate_transpose_core
    import mfrt_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ELEM_W-1:0]    element_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ELEM_W-1:0]    out_value,
    output logic                 last_flag,
    output logic                 shape_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = $clog2(MAX_DIM);

    logic [CFG_W-1:0]      row_count_reg;
    logic [CFG_W-1:0]      col_count_reg;
    mode_t                 mode_reg;
    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     load_count_reg, load_count_next;
    logic [IDX_W-1:0]      r_reg, r_next;
    logic [IDX_W-1:0]      c_reg, c_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  last_reg;
    logic                  err_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [DIM_W-1:0]      rows, cols;
    logic [IDX_W-1:0]      rows_m1, cols_m1;
    logic [CNT_W-1:0]      total;
    logic                  err;
    logic                  in_acc, load_done;
    logic                  rd_en, rd_last;
    logic [IDX_W-1:0]      row_sel, col_sel;
    logic [ADDR_W-1:0]     rd_addr;

    always_comb
    begin
        if (row_count_reg == '0)
            rows = DIM_W'(1);
        else if (row_count_reg > CFG_W'(MAX_DIM))
            rows = DIM_W'(MAX_DIM);
        else
            rows = DIM_W'(row_count_reg);
        if (col_count_reg == '0)
            cols = DIM_W'(1);
        else if (col_count_reg > CFG_W'(MAX_DIM))
            cols = DIM_W'(MAX_DIM);
        else
            cols = DIM_W'(col_count_reg);
    end

    assign rows_m1 = IDX_W'(rows - DIM_W'(1));
    assign cols_m1 = IDX_W'(cols - DIM_W'(1));
    assign total = CNT_W'(CNT_W'(rows) * CNT_W'(cols));
    assign err = (mode_reg == MODE_TRANSPOSE) && (rows != cols);

    assign in_stall = (state_reg == ST_EMIT);
    assign in_acc = in_valid && !in_stall;
    assign load_done = (CNT_W'(load_count_reg) + CNT_W'(1)) >= total;

    assign rd_en = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign rd_last = (r_reg == rows_m1) && (c_reg == cols_m1);

    always_comb
    begin
        row_sel = r_reg;
        col_sel = c_reg;
        unique case (mode_reg)
            MODE_MIRROR:
            begin
                col_sel = cols_m1 - c_reg;
            end
            MODE_FLIP:
            begin
                row_sel = rows_m1 - r_reg;
            end
            MODE_ROTATE:
            begin
                row_sel = rows_m1 - r_reg;
                col_sel = cols_m1 - c_reg;
            end
            MODE_TRANSPOSE:
            begin
                if (!err)
                begin
                    row_sel = c_reg;
                    col_sel = r_reg;
                end
            end
            default:
            begin
                row_sel = r_reg;
            end
        endcase
    end

    assign rd_addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(cols) + ADDR_W'(col_sel));

    always_comb
    begin
        state_next = state_reg;
        load_count_next = load_count_reg;
        r_next = r_reg;
        c_next = c_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_done)
                    begin
                        load_count_next = '0;
                        r_next = '0;
                        c_next = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + ADDR_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (rd_en)
                begin
                    out_valid_next = 1'b1;
                    if (c_reg == cols_m1)
                    begin
                        c_next = '0;
                        r_next = r_reg + IDX_W'(1);
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                    if (rd_last)
                        state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            load_count_reg <= '0;
            r_reg <= '0;
            c_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            load_count_reg <= load_count_next;
            r_reg <= r_next;
            c_reg <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
            col_count_reg <= COL_COUNT_RESET;
            mode_reg <= MODE_MIRROR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg <= cfg_data;
                REG_COL_COUNT:    col_count_reg <= cfg_data;
                REG_REORDER_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                default:          mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            mem[load_count_reg] <= DATA_WIDTH'(element_value);
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            last_reg <= rd_last;
            err_reg <= err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = ELEM_W'(rd_data_reg);
    assign last_flag = last_reg;
    assign shape_error = err_reg;

endmodule

### rtl/mfrt_checker.sv
// Port-level checker for the matrix flip, rotate and transpose core.
// Depends on mfrt_pkg and binds to matrix_flip_rotate_transpose_core.
module mfrt_checker
    import mfrt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ELEM_W-1:0] out_value,
    input logic              last_flag,
    input logic              shape_error
);

    // While a matrix is still being emitted, no new item may be loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_flag |-> in_stall)
        else $error("item accepted while a matrix was still being emitted");

    // The shape flag does not change between results of one matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_flag |=> $stable(shape_error))
        else $error("shape flag changed within one matrix");

    // Emission does not pause between results of one matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_flag |=> out_valid)
        else $error("gap in emission before the final result");

    // A stalled result holds its value and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value)
            && $stable(last_flag) && $stable(shape_error))
        else $error("stalled result changed");

endmodule

bind matrix_flip_rotate_transpose_core mfrt_checker u_mfrt_checker (.*);

### test/tb.sv
// Testbench for matrix_flip_rotate_transpose_core: loads matrices of many shapes and
// modes and checks every reordered element against a scoreboard that predicts them.
// Depends on mfrt_pkg and the core itself.
`timescale 1ns / 100ps

import mfrt_pkg::*;

typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
    logic              err;
} reordered_t;

class reorder_checker;
    localparam int MAX_DIM = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEM_W-1:0] shadow_store [STORE_DEPTH];
    int unsigned       load_pos;
    logic [CFG_W-1:0]  row_reg;
    logic [CFG_W-1:0]  col_reg;
    mode_t             mode_reg;
    reordered_t        reordered_q [$];
    int                errors;

    function new();
        load_pos = 0;
        row_reg = ROW_COUNT_RESET;
        col_reg = COL_COUNT_RESET;
        mode_reg = MODE_MIRROR;
        errors = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function int unsigned element_total();
        return clamp_dim(row_reg) * clamp_dim(col_reg);
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_W-1:0] d);
        case (idx)
            REG_ROW_COUNT:    row_reg = d;
            REG_COL_COUNT:    col_reg = d;
            REG_REORDER_MODE: mode_reg = mode_t'(d[1:0]);
            default:          ;
        endcase
    endfunction

    function void note_element(logic [ELEM_W-1:0] v);
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        int unsigned pos;
        int unsigned src;
        int unsigned r;
        int unsigned c;
        logic        err;
        reordered_t  item;
        rows = clamp_dim(row_reg);
        cols = clamp_dim(col_reg);
        total = rows * cols;
        pos = load_pos % STORE_DEPTH;
        shadow_store[pos] = v;
        if (pos + 1 < total)
        begin
            load_pos = (pos + 1) & 'h7F;
            return;
        end
        load_pos = 0;
        err = (mode_reg == MODE_TRANSPOSE) && (rows != cols);
        for (int unsigned p = 0; p < total; p++)
        begin
            r = p / cols;
            c = p % cols;
            case (mode_reg)
                MODE_MIRROR: src = r * cols + (cols - 1 - c);
                MODE_FLIP:   src = (rows - 1 - r) * cols + c;
                MODE_ROTATE: src = total - 1 - p;
                default:     src = err ? p : c * cols + r;
            endcase
            item.value = shadow_store[src % STORE_DEPTH];
            item.last = (p + 1 == total);
            item.err = err;
            reordered_q.push_back(item);
        end
    endfunction

    function int pending_count();
        return reordered_q.size();
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic [ELEM_W-1:0] v, logic last, logic err);
        reordered_t want;
        if (reordered_q.size() == 0)
        begin
            report($sformatf("unexpected result value=%h last=%b err=%b", v, last, err));
            return;
        end
        want = reordered_q.pop_front();
        if (v !== want.value)
            report($sformatf("out_value %h, expected %h", v, want.value));
        if (last !== want.last)
            report($sformatf("last_flag %b, expected %b", last, want.last));
        if (err !== want.err)
            report($sformatf("shape_error %b, expected %b", err, want.err));
    endtask
endclass

module tb;
    localparam int TOTAL_ITEMS = 410;
    localparam int IDLE_PCT = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    reg_index_t        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [ELEM_W-1:0] element_value;
    logic              out_valid;
    logic              out_stall;
    logic [ELEM_W-1:0] out_value;
    logic              last_flag;
    logic              shape_error;

    reorder_checker    sb;
    bit                steady;
    int                hold_requests;
    int                items_sent;
    int                quiet_cycles = 0;

    matrix_flip_rotate_transpose_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .last_flag     (last_flag),
        .shape_error   (shape_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
                             input logic [CFG_W-1:0] m);
        write_reg(REG_ROW_COUNT, r);
        write_reg(REG_COL_COUNT, c);
        write_reg(REG_REORDER_MODE, m);
    endtask

    task automatic send_element(input logic [ELEM_W-1:0] v);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        element_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_element(v);
        items_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
        else if (sel < 80)
            return 4'($urandom_range(4, 1));
        return 4'($urandom_range(8, 5));
    endfunction

    initial
    begin
        int unsigned sel;
        int unsigned phase;
        int unsigned total;
        int unsigned count;
        int unsigned matrices;
        logic [ELEM_W-1:0] v;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROW_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        element_value = '0;
        steady = 1'b0;
        hold_requests = 0;
        items_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(4'd1, 4'd1, 4'(MODE_MIRROR));
        write_reg(REG_UNUSED, 4'hF);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        wait_quiet();

        configure(4'd2, 4'd2, 4'(MODE_TRANSPOSE));
        send_element(32'h8000_0000);
        send_element(32'h7FFF_FFFF);
        send_element(32'h0000_0001);
        send_element(32'hAAAA_AAAA);
        wait_quiet();

        configure(4'd1, 4'd2, 4'(MODE_TRANSPOSE));
        send_element(32'h5555_5555);
        send_element(32'hFFFF_FFFE);
        wait_quiet();

        configure(4'd0, 4'd2, {2'b11, MODE_FLIP});
        send_element(32'h1234_5678);
        send_element(32'hFEDC_BA98);
        wait_quiet();

        configure(4'd9, 4'd1, {2'b01, MODE_ROTATE});
        for (int i = 0; i < 8; i++)
            send_element(32'h0100_0000 * i + 32'hF0);
        wait_quiet();

        configure(4'd1, 4'd4, 4'(MODE_MIRROR));
        send_element(32'hDEAD_BEEF);
        send_element(32'h0BAD_F00D);
        send_element(32'hCAFE_0001);
        wait_quiet();
        write_reg(REG_COL_COUNT, 4'd2);
        send_element(32'h0000_FFFF);
        wait_quiet();

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            phase++;
            if (phase == 1)
                configure(4'd8, 4'd8, 4'($urandom_range(15)));
            else
                configure(pick_dim(), pick_dim(), 4'($urandom_range(15)));
            total = sb.element_total();
            matrices = $urandom_range(3, 1);
            if (phase == 2 && matrices < 2)
                matrices = 2;
            count = matrices * total;
            if ($urandom_range(99) < 20)
                count += $urandom_range(total, 1) - 1;
            if (items_sent + count > TOTAL_ITEMS)
                count = 32'(TOTAL_ITEMS - items_sent);
            steady = (phase == 1 || phase == 3);
            if (phase == 2)
                hold_requests++;
            for (int unsigned i = 0; i < count; i++)
            begin
                sel = $urandom_range(99);
                if (sel < 3)
                    v = 32'h0000_0000;
                else if (sel < 6)
                    v = 32'hFFFF_FFFF;
                else if (sel < 8)
                    v = 32'h8000_0000;
                else if (sel < 10)
                    v = 32'h7FFF_FFFF;
                else
                    v = $urandom;
                send_element(v);
            end
            wait_quiet();
            steady = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending_count()));
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int served;
        served = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != served)
            begin
                served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_value, last_flag, shape_error);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved in %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end
endmodule
